// ===== rtl/tempo_grid_quantizer_defines.svh =====
// assertion macros used by the tempo grid quantizer checker
`ifndef TEMPO_GRID_QUANTIZER_DEFINES_SVH
`define TEMPO_GRID_QUANTIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TGQ_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tgq_pkg.sv =====
// shared types, codes and constants of the tempo grid quantizer
package tgq_pkg;

	localparam int STATE_BITS     = 48;
	localparam int BEAT_IN_BITS   = 40;
	localparam int BEAT_OUT_BITS  = 48;
	localparam int POS_BITS_DEF   = 40;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int TEMPO_BITS     = 17;
	localparam int RATE_BITS      = 19;
	localparam int DIV_BITS       = 7;
	localparam int CFG_IDX_BITS   = 2;
	localparam int CFG_DATA_BITS  = 19;

	localparam logic [TEMPO_BITS-1:0] TEMPO_RST = 17'd12000;
	localparam logic [RATE_BITS-1:0]  RATE_RST  = 19'd44100;
	localparam logic [DIV_BITS-1:0]   DIV_RST   = 7'd16;

	// seconds per minute times hundredths of a beat
	localparam int RATE_MUL       = 6000;
	localparam int RATE_PROD_BITS = 32;

	localparam logic [2:0] REQ_NEAREST      = 3'd0;
	localparam logic [2:0] REQ_NEXT         = 3'd1;
	localparam logic [2:0] REQ_PREV         = 3'd2;
	localparam logic [2:0] REQ_SMP_TO_BEATS = 3'd3;
	localparam logic [2:0] REQ_SMP_TO_BARS  = 3'd4;
	localparam logic [2:0] REQ_BEATS_TO_SMP = 3'd5;
	localparam logic [2:0] REQ_BARS_TO_SMP  = 3'd6;

	localparam logic [CFG_IDX_BITS-1:0] CFG_TEMPO = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RATE  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DIV   = 2'd2;

	typedef enum logic [1:0] {
		CAL_IDLE,
		CAL_LOAD,
		CAL_RUN
	} tgq_cal_state_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] req;
	} tgq_ctrl_t;

endpackage

// ===== rtl/tempo_grid_quantizer.sv =====
// top level of the tempo grid quantizer
// Accepts one word per clock while busy is low and returns exactly one result
// word per request, marked by a one-cycle done strobe that cannot be held off.
// Each word passes through the chain of restoring-division cells, one quotient
// bit per cell, followed by rounding, a split multiplier and the output register.
// After reset and after every write to a valid register index, busy stays high
// while the bit-serial divider recomputes the beat and grid lengths; configure
// only when no result is outstanding.
module tempo_grid_quantizer #(
	parameter int POS_BITS  = tgq_pkg::POS_BITS_DEF,
	parameter int FRAC_BITS = tgq_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [2:0]                           req_type,
	input  logic [POS_BITS-1:0]                  sample_pos,
	input  logic [tgq_pkg::BEAT_IN_BITS-1:0]     beat_value,
	output logic                                 done,
	output logic [POS_BITS-1:0]                  sample_result,
	output logic [tgq_pkg::BEAT_OUT_BITS-1:0]    beat_result,
	output logic                                 saturated,
	input  logic                                 cfg_we,
	input  logic [tgq_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [tgq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

	localparam int SB = tgq_pkg::STATE_BITS;
	localparam int QW = POS_BITS + 2 * FRAC_BITS;

	logic [SB-1:0] spb, spg;

	tgq_pkg::tgq_ctrl_t ctrl_c [QW+1];
	logic [POS_BITS-1:0] pos_c [QW+1];
	logic [tgq_pkg::BEAT_IN_BITS-1:0] beats_c [QW+1];
	logic [SB-1:0] rem_c [QW+1];
	logic [QW-1:0] quo_c [QW+1];

	tgq_cal #(
		.FRAC_BITS(FRAC_BITS)
	) u_cal (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.spb       (spb),
		.spg       (spg)
	);

	always_comb begin
		ctrl_c[0].valid = start && !busy;
		ctrl_c[0].req   = req_type;
		pos_c[0]        = sample_pos;
		beats_c[0]      = beat_value;
		rem_c[0]        = '0;
		quo_c[0]        = '0;
	end

	// cell i resolves quotient bit QW-1-i
	for (genvar i = 0; i < QW; i++) begin : g_cell
		tgq_div_cell #(
			.POS_BITS  (POS_BITS),
			.FRAC_BITS (FRAC_BITS),
			.BIT       (QW - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl_in   (ctrl_c[i]),
			.pos_in    (pos_c[i]),
			.beats_in  (beats_c[i]),
			.rem_in    (rem_c[i]),
			.quo_in    (quo_c[i]),
			.spb       (spb),
			.spg       (spg),
			.ctrl_out  (ctrl_c[i+1]),
			.pos_out   (pos_c[i+1]),
			.beats_out (beats_c[i+1]),
			.rem_out   (rem_c[i+1]),
			.quo_out   (quo_c[i+1])
		);
	end

	tgq_post #(
		.POS_BITS  (POS_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl_in       (ctrl_c[QW]),
		.pos_in        (pos_c[QW]),
		.beats_in      (beats_c[QW]),
		.rem_in        (rem_c[QW]),
		.quo_in        (quo_c[QW]),
		.spb           (spb),
		.spg           (spg),
		.done          (done),
		.sample_result (sample_result),
		.beat_result   (beat_result),
		.saturated     (saturated)
	);

endmodule

// ===== rtl/tgq_cal.sv =====
// configuration registers and bit-serial recalculation of beat and grid lengths
module tgq_cal #(
	parameter int FRAC_BITS = tgq_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tgq_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  logic [tgq_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	output logic                                 busy,
	output logic [tgq_pkg::STATE_BITS-1:0]       spb,
	output logic [tgq_pkg::STATE_BITS-1:0]       spg
);

	localparam int SB = tgq_pkg::STATE_BITS;
	localparam int NW = tgq_pkg::RATE_PROD_BITS + FRAC_BITS;
	localparam int DW = NW + 2;
	localparam int TW = tgq_pkg::TEMPO_BITS;
	localparam int GW = tgq_pkg::TEMPO_BITS + tgq_pkg::DIV_BITS;
	localparam int EW = (DW > SB) ? DW : SB;
	localparam int CW = $clog2(DW);

	logic [tgq_pkg::TEMPO_BITS-1:0] tempo_q;
	logic [tgq_pkg::RATE_BITS-1:0]  rate_q;
	logic [tgq_pkg::DIV_BITS-1:0]   div_q;

	tgq_pkg::tgq_cal_state_t state_q, state_nx;
	logic cfg_hit, do_load, do_step, last;

	logic [DW-1:0] num_q, qb_q, qg_q, qb_nx, qg_nx;
	logic [TW-1:0] remb_q, denb_q;
	logic [GW-1:0] remg_q, deng_q;
	logic [CW-1:0] cnt_q;
	logic [tgq_pkg::RATE_PROD_BITS-1:0] rate_prod;
	logic [TW:0] tb, db;
	logic [GW:0] tg, dg;
	logic geb, geg;
	logic [EW-1:0] qb_ext, qg_ext;

	assign cfg_hit = cfg_we && (cfg_idx == tgq_pkg::CFG_TEMPO || cfg_idx == tgq_pkg::CFG_RATE
		|| cfg_idx == tgq_pkg::CFG_DIV);
	assign last = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= tgq_pkg::TEMPO_RST;
			rate_q  <= tgq_pkg::RATE_RST;
			div_q   <= tgq_pkg::DIV_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				tgq_pkg::CFG_TEMPO: tempo_q <= cfg_wdata[tgq_pkg::TEMPO_BITS-1:0];
				tgq_pkg::CFG_RATE:  rate_q  <= cfg_wdata[tgq_pkg::RATE_BITS-1:0];
				tgq_pkg::CFG_DIV:   div_q   <= cfg_wdata[tgq_pkg::DIV_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		priority if (cfg_hit) begin
			state_nx = tgq_pkg::CAL_LOAD;
		end else begin
			unique case (state_q)
				tgq_pkg::CAL_IDLE: state_nx = tgq_pkg::CAL_IDLE;
				tgq_pkg::CAL_LOAD: state_nx = tgq_pkg::CAL_RUN;
				tgq_pkg::CAL_RUN:  state_nx = last ? tgq_pkg::CAL_IDLE : tgq_pkg::CAL_RUN;
				default:           state_nx = tgq_pkg::CAL_IDLE;
			endcase
		end
	end

	always_comb begin
		busy    = (state_q != tgq_pkg::CAL_IDLE);
		do_load = (state_q == tgq_pkg::CAL_LOAD);
		do_step = (state_q == tgq_pkg::CAL_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgq_pkg::CAL_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (do_load) begin
				cnt_q <= CW'(DW - 1);
			end else if (do_step && !last) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// one restoring step for each divider; beat length uses the same stream and drops two bits
	always_comb begin
		rate_prod = tgq_pkg::RATE_PROD_BITS'(32'(rate_q) * 32'(tgq_pkg::RATE_MUL));
		tb    = {remb_q, num_q[DW-1]};
		tg    = {remg_q, num_q[DW-1]};
		db    = {1'b0, denb_q};
		dg    = {1'b0, deng_q};
		geb   = (tb >= db);
		geg   = (tg >= dg);
		qb_nx = {qb_q[DW-2:0], geb};
		qg_nx = {qg_q[DW-2:0], geg};
		qb_ext = EW'(qb_nx >> 2);
		qg_ext = EW'(qg_nx);
	end

	always_ff @(posedge clk) begin
		if (do_load) begin
			num_q  <= DW'(rate_prod) << (FRAC_BITS + 2);
			remb_q <= '0;
			remg_q <= '0;
			qb_q   <= '0;
			qg_q   <= '0;
			denb_q <= tempo_q;
			deng_q <= GW'(tempo_q) * GW'(div_q);
		end else if (do_step) begin
			num_q  <= num_q << 1;
			remb_q <= geb ? TW'(tb - db) : tb[TW-1:0];
			remg_q <= geg ? GW'(tg - dg) : tg[GW-1:0];
			qb_q   <= qb_nx;
			qg_q   <= qg_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spb <= '0;
			spg <= '0;
		end else if (do_step && last) begin
			if (denb_q == '0) begin
				spb <= '0;
			end else if (qb_ext > EW'({SB{1'b1}})) begin
				spb <= '1;
			end else begin
				spb <= qb_ext[SB-1:0];
			end
			if (deng_q == '0) begin
				spg <= '0;
			end else if (qg_ext > EW'({SB{1'b1}})) begin
				spg <= '1;
			end else begin
				spg <= qg_ext[SB-1:0];
			end
		end
	end

endmodule

// ===== rtl/tgq_div_cell.sv =====
// one restoring division step of the position divider chain
module tgq_div_cell #(
	parameter int POS_BITS  = tgq_pkg::POS_BITS_DEF,
	parameter int FRAC_BITS = tgq_pkg::FRAC_BITS_DEF,
	parameter int BIT       = 0
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tgq_pkg::tgq_ctrl_t                      ctrl_in,
	input  logic [POS_BITS-1:0]                     pos_in,
	input  logic [tgq_pkg::BEAT_IN_BITS-1:0]        beats_in,
	input  logic [tgq_pkg::STATE_BITS-1:0]          rem_in,
	input  logic [POS_BITS+2*FRAC_BITS-1:0]         quo_in,
	input  logic [tgq_pkg::STATE_BITS-1:0]          spb,
	input  logic [tgq_pkg::STATE_BITS-1:0]          spg,
	output tgq_pkg::tgq_ctrl_t                      ctrl_out,
	output logic [POS_BITS-1:0]                     pos_out,
	output logic [tgq_pkg::BEAT_IN_BITS-1:0]        beats_out,
	output logic [tgq_pkg::STATE_BITS-1:0]          rem_out,
	output logic [POS_BITS+2*FRAC_BITS-1:0]         quo_out
);

	localparam int SB = tgq_pkg::STATE_BITS;
	localparam int QW = POS_BITS + 2 * FRAC_BITS;

	logic bit_b, bit_g, num_bit, use_beat, ge;
	logic [SB-1:0] d;
	logic [SB:0] t, diff;

	// numerator bit of this cell: position shifted by two fraction widths or by one
	if (BIT >= 2 * FRAC_BITS) begin : g_bit_b
		assign bit_b = pos_in[BIT-2*FRAC_BITS];
	end else begin : g_bit_b0
		assign bit_b = 1'b0;
	end
	if (BIT >= FRAC_BITS && BIT < POS_BITS + FRAC_BITS) begin : g_bit_g
		assign bit_g = pos_in[BIT-FRAC_BITS];
	end else begin : g_bit_g0
		assign bit_g = 1'b0;
	end

	always_comb begin
		use_beat = (ctrl_in.req == tgq_pkg::REQ_SMP_TO_BEATS)
			|| (ctrl_in.req == tgq_pkg::REQ_SMP_TO_BARS);
		d       = use_beat ? spb : spg;
		num_bit = use_beat ? bit_b : bit_g;
		t       = {rem_in, num_bit};
		diff    = t - {1'b0, d};
		ge      = (t >= {1'b0, d});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_out <= '0;
		end else begin
			ctrl_out <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		pos_out   <= pos_in;
		beats_out <= beats_in;
		rem_out   <= ge ? diff[SB-1:0] : t[SB-1:0];
		quo_out   <= {quo_in[QW-2:0], ge};
	end

endmodule

// ===== rtl/tgq_post.sv =====
// rounding, multiply back and saturation behind the divider chain
module tgq_post #(
	parameter int POS_BITS  = tgq_pkg::POS_BITS_DEF,
	parameter int FRAC_BITS = tgq_pkg::FRAC_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  tgq_pkg::tgq_ctrl_t                      ctrl_in,
	input  logic [POS_BITS-1:0]                     pos_in,
	input  logic [tgq_pkg::BEAT_IN_BITS-1:0]        beats_in,
	input  logic [tgq_pkg::STATE_BITS-1:0]          rem_in,
	input  logic [POS_BITS+2*FRAC_BITS-1:0]         quo_in,
	input  logic [tgq_pkg::STATE_BITS-1:0]          spb,
	input  logic [tgq_pkg::STATE_BITS-1:0]          spg,
	output logic                                    done,
	output logic [POS_BITS-1:0]                     sample_result,
	output logic [tgq_pkg::BEAT_OUT_BITS-1:0]       beat_result,
	output logic                                    saturated
);

	localparam int SB = tgq_pkg::STATE_BITS;
	localparam int BI = tgq_pkg::BEAT_IN_BITS;
	localparam int BO = tgq_pkg::BEAT_OUT_BITS;
	localparam int QW = POS_BITS + 2 * FRAC_BITS;
	localparam int KW = POS_BITS + FRAC_BITS + 1;
	localparam int AW = (KW > BI) ? KW : BI;
	localparam int AL = AW / 2;
	localparam int AH = AW - AL;
	localparam int BL = SB / 2;
	localparam int BH = SB - BL;
	localparam int PW = AW + SB;
	localparam int SW = PW + 2;
	localparam int EW = (QW > BO) ? QW : BO;

	logic [KW-1:0] k, kadj;
	logic [SB-1:0] gdiff;
	logic [EW-1:0] q;
	logic [AW-1:0] a_nx;
	logic [SB-1:0] b_nx;
	logic [BO-1:0] bres_nx;
	logic bsat_nx;

	tgq_pkg::tgq_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3;
	logic [AW-1:0] a_s1;
	logic [SB-1:0] b_s1;
	logic [POS_BITS-1:0] pos_s1, pos_s2, pos_s3;
	logic gz_s1, gz_s2, gz_s3;
	logic [BO-1:0] bres_s1, bres_s2, bres_s3;
	logic bsat_s1, bsat_s2, bsat_s3;
	logic [AL+BL-1:0] pp_ll_s2;
	logic [AL+BH-1:0] pp_lh_s2;
	logic [AH+BL-1:0] pp_hl_s2;
	logic [AH+BH-1:0] pp_hh_s2;
	logic [PW-1:0] prod_s3;

	logic [SW-1:0] scaled;
	logic [POS_BITS-1:0] sres_nx;
	logic [BO-1:0] bres_out;
	logic ssat_nx, bsat_out;

	// grid index rounding and operand select
	always_comb begin
		k     = KW'(quo_in[POS_BITS+FRAC_BITS-1:0]);
		gdiff = spg - rem_in;
		kadj  = k;
		a_nx  = '0;
		b_nx  = spb;
		unique case (ctrl_in.req)
			tgq_pkg::REQ_NEAREST: begin
				kadj = (rem_in >= gdiff) ? k + KW'(1) : k;
				a_nx = AW'(kadj);
				b_nx = spg;
			end
			tgq_pkg::REQ_NEXT: begin
				kadj = k + KW'(1);
				a_nx = AW'(kadj);
				b_nx = spg;
			end
			tgq_pkg::REQ_PREV: begin
				// exact grid hit steps back one point, never below zero
				kadj = (rem_in == '0 && k != '0) ? k - KW'(1) : k;
				a_nx = AW'(kadj);
				b_nx = spg;
			end
			tgq_pkg::REQ_BEATS_TO_SMP, tgq_pkg::REQ_BARS_TO_SMP: begin
				a_nx = AW'(beats_in);
			end
			default: ;
		endcase
	end

	always_comb begin
		q       = EW'(quo_in);
		bres_nx = '0;
		bsat_nx = 1'b0;
		if (ctrl_in.req == tgq_pkg::REQ_SMP_TO_BARS) begin
			q = q >> 2;
		end
		if ((ctrl_in.req == tgq_pkg::REQ_SMP_TO_BEATS || ctrl_in.req == tgq_pkg::REQ_SMP_TO_BARS)
			&& spb != '0) begin
			if (q > EW'({BO{1'b1}})) begin
				bres_nx = '1;
				bsat_nx = 1'b1;
			end else begin
				bres_nx = q[BO-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			done    <= 1'b0;
		end else begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			done    <= ctrl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a_nx;
		b_s1    <= b_nx;
		pos_s1  <= pos_in;
		gz_s1   <= (spg == '0);
		bres_s1 <= bres_nx;
		bsat_s1 <= bsat_nx;

		pp_ll_s2 <= a_s1[AL-1:0] * b_s1[BL-1:0];
		pp_lh_s2 <= a_s1[AL-1:0] * b_s1[SB-1:BL];
		pp_hl_s2 <= a_s1[AW-1:AL] * b_s1[BL-1:0];
		pp_hh_s2 <= a_s1[AW-1:AL] * b_s1[SB-1:BL];
		pos_s2   <= pos_s1;
		gz_s2    <= gz_s1;
		bres_s2  <= bres_s1;
		bsat_s2  <= bsat_s1;

		prod_s3 <= PW'(pp_ll_s2) + (PW'(pp_lh_s2) << BL) + (PW'(pp_hl_s2) << AL)
			+ (PW'(pp_hh_s2) << (AL + BL));
		pos_s3  <= pos_s2;
		gz_s3   <= gz_s2;
		bres_s3 <= bres_s2;
		bsat_s3 <= bsat_s2;
	end

	// scale the product back to samples and clip, or pass the beat result through
	always_comb begin
		scaled   = '0;
		sres_nx  = '0;
		ssat_nx  = 1'b0;
		bres_out = '0;
		bsat_out = 1'b0;
		unique case (ctrl_s3.req)
			tgq_pkg::REQ_NEAREST, tgq_pkg::REQ_NEXT, tgq_pkg::REQ_PREV: begin
				scaled = SW'(prod_s3) >> FRAC_BITS;
			end
			tgq_pkg::REQ_BEATS_TO_SMP: begin
				scaled = SW'(prod_s3) >> (2 * FRAC_BITS);
			end
			tgq_pkg::REQ_BARS_TO_SMP: begin
				scaled = (SW'(prod_s3) << 2) >> (2 * FRAC_BITS);
			end
			tgq_pkg::REQ_SMP_TO_BEATS, tgq_pkg::REQ_SMP_TO_BARS: begin
				bres_out = bres_s3;
				bsat_out = bsat_s3;
			end
			default: ;
		endcase
		if (scaled > SW'({POS_BITS{1'b1}})) begin
			sres_nx = '1;
			ssat_nx = 1'b1;
		end else begin
			sres_nx = scaled[POS_BITS-1:0];
		end
		if ((ctrl_s3.req == tgq_pkg::REQ_NEAREST || ctrl_s3.req == tgq_pkg::REQ_NEXT
			|| ctrl_s3.req == tgq_pkg::REQ_PREV) && gz_s3) begin
			sres_nx = pos_s3;
			ssat_nx = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		sample_result <= sres_nx;
		beat_result   <= bres_out;
		saturated     <= ssat_nx | bsat_out;
	end

endmodule

// ===== rtl/tgq_checker.sv =====
// port-level checker of the tempo grid quantizer and its bind
`include "tempo_grid_quantizer_defines.svh"

module tgq_checker #(
	parameter int POS_BITS  = tgq_pkg::POS_BITS_DEF,
	parameter int FRAC_BITS = tgq_pkg::FRAC_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 done,
	input logic [POS_BITS-1:0]                  sample_result,
	input logic [tgq_pkg::BEAT_OUT_BITS-1:0]    beat_result,
	input logic                                 saturated,
	input logic                                 cfg_we,
	input logic [tgq_pkg::CFG_IDX_BITS-1:0]     cfg_idx
);

	localparam int LAT = POS_BITS + 2 * FRAC_BITS + 4;

	logic cfg_hit, acc;

	assign cfg_hit = cfg_we && (cfg_idx == tgq_pkg::CFG_TEMPO || cfg_idx == tgq_pkg::CFG_RATE
		|| cfg_idx == tgq_pkg::CFG_DIV);
	assign acc = start && !busy;

	`TGQ_ASSERT_NEXT(a_cfg_busy, clk, arst_n, cfg_hit, busy, "no recalculation after write")
	`TGQ_ASSERT_IMPLIES(a_done_lat, clk, arst_n, done, $past(acc, LAT), "result without word")
	`TGQ_ASSERT_IMPLIES(a_one_kind, clk, arst_n, done && beat_result != '0, sample_result == '0, "both fields set")
	`TGQ_ASSERT_IMPLIES(a_beat_clip, clk, arst_n, done && saturated && beat_result != '0, &beat_result, "beat clip not at max")

endmodule

bind tempo_grid_quantizer tgq_checker #(
	.POS_BITS  (POS_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_tgq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.sample_result (sample_result),
	.beat_result   (beat_result),
	.saturated     (saturated),
	.cfg_we        (cfg_we),
	.cfg_idx       (cfg_idx)
);
